FILE: rtl/core/gbn_pkg.sv
// Shared types and codes for the go-back-n sender window control.
package gbn_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int MAX_BURST        = 8;
    localparam int TAG_W            = 16;
    localparam int SEQ_W            = 32;
    localparam int CNT_W            = 4;
    localparam int WSIZE_W          = 4;

    localparam logic [1:0] ACT_SEND    = 2'd0;
    localparam logic [1:0] ACT_ACK     = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [2:0] KIND_NEW        = 3'd0;
    localparam logic [2:0] KIND_REFUSED    = 3'd1;
    localparam logic [2:0] KIND_ACK_OK     = 3'd2;
    localparam logic [2:0] KIND_ACK_IGN    = 3'd3;
    localparam logic [2:0] KIND_RETX       = 3'd4;
    localparam logic [2:0] KIND_TMO_EMPTY  = 3'd5;

    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;
    localparam logic [1:0] TMR_RESTART = 2'd3;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]       action;
        logic [TAG_W-1:0] payload_tag;
        logic [SEQ_W-1:0] ack_number;
        logic             ack_intact;
    } t_gbn_in;

    typedef struct packed {
        logic [2:0]       result_kind;
        logic [SEQ_W-1:0] packet_seq;
        logic [TAG_W-1:0] packet_tag;
        logic [1:0]       timer_action;
        logic [SEQ_W-1:0] timer_seq;
        logic             window_full;
        logic [CNT_W-1:0] in_flight;
        logic             last;
    } t_gbn_out;

    typedef struct packed {
        logic accept;
        logic decide;
        logic replay;
    } t_gbn_cmd;

    typedef struct packed {
        logic replay_start;
        logic replay_last;
    } t_gbn_stat;

endpackage

FILE: rtl/core/gbn_ctrl.sv
// Sequencer for the go-back-n sender: accept, decide, replay.
module gbn_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gbn_pkg::t_gbn_stat   i_stat,
    output gbn_pkg::t_gbn_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_REPLAY = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = i_stat.replay_start ? S_REPLAY : S_IDLE;
            end
            S_REPLAY: begin
                if (i_stat.replay_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cmd.accept  = start && (r_state == S_IDLE);
    assign o_cmd.decide  = (r_state == S_DECIDE);
    assign o_cmd.replay  = (r_state == S_REPLAY);

endmodule

FILE: rtl/core/gbn_dp.sv
// Window state, tag ring memory and result register of the go-back-n sender.
module gbn_dp #(
    parameter int WINDOW_DEPTH = gbn_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gbn_pkg::t_gbn_cmd                 i_cmd,
    output gbn_pkg::t_gbn_stat                o_stat,
    input  gbn_pkg::t_gbn_in                  i_in,
    input  logic                              i_cfg_we,
    input  logic [gbn_pkg::WSIZE_W-1:0]       i_cfg_wdata,
    output logic                              o_res_strobe,
    output gbn_pkg::t_gbn_out                 o_res
);

    localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SW  = AW + gbn_pkg::CNT_W;
    localparam int LIM = (WINDOW_DEPTH < gbn_pkg::MAX_BURST) ? WINDOW_DEPTH
                                                             : gbn_pkg::MAX_BURST;
    localparam int IW  = $clog2(gbn_pkg::MAX_BURST);
    localparam logic [gbn_pkg::CNT_W-1:0] WIN_LIM = gbn_pkg::CNT_W'(LIM);
    localparam logic [SW-1:0]             DEPTH_S = SW'(WINDOW_DEPTH);
    localparam logic [AW-1:0]             TOP_SLOT = AW'(WINDOW_DEPTH - 1);

    gbn_pkg::t_gbn_in                   r_in;
    logic [gbn_pkg::WSIZE_W-1:0]        r_wsize;
    logic [gbn_pkg::SEQ_W-1:0]          r_base;
    logic [gbn_pkg::SEQ_W-1:0]          r_next;
    logic [gbn_pkg::CNT_W-1:0]          r_count;
    logic [AW-1:0]                      r_head;
    logic [AW-1:0]                      r_rd_slot;
    logic [IW-1:0]                      r_idx;
    logic [gbn_pkg::TAG_W-1:0]          r_rd_tag;
    logic [gbn_pkg::TAG_W-1:0]          ring [WINDOW_DEPTH];
    logic                               r_strobe;
    gbn_pkg::t_gbn_out                  r_res;

    logic [gbn_pkg::CNT_W-1:0]          eff;
    logic [SW-1:0]                      wr_sum;
    logic [AW-1:0]                      wr_slot;
    logic [gbn_pkg::CNT_W-1:0]          ack_num;
    logic [SW-1:0]                      ack_sum;
    logic [AW-1:0]                      ack_head;
    logic [gbn_pkg::SEQ_W-1:0]          ack_plus1;
    logic [AW-1:0]                      rd_addr;
    logic [AW-1:0]                      rd_inc;
    logic                               send_ok;
    logic                               ack_ok;
    logic                               dec_emit;
    logic                               ring_we;
    logic [gbn_pkg::CNT_W-1:0]          n_count;
    gbn_pkg::t_gbn_out                  dec_res;
    gbn_pkg::t_gbn_out                  rep_res;

    assign eff = (r_wsize > WIN_LIM) ? WIN_LIM : r_wsize;

    // next free slot of the ring
    assign wr_sum  = SW'(r_head) + SW'(r_count);
    assign wr_slot = (wr_sum >= DEPTH_S) ? AW'(wr_sum - DEPTH_S) : AW'(wr_sum);

    assign ack_plus1 = r_in.ack_number + 32'd1;
    assign ack_num   = gbn_pkg::CNT_W'(ack_plus1 - r_base);
    assign ack_sum   = SW'(r_head) + SW'(ack_num);
    assign ack_head  = (ack_sum >= DEPTH_S) ? AW'(ack_sum - DEPTH_S) : AW'(ack_sum);

    assign send_ok = (r_count < eff) && (r_next != '1);
    assign ack_ok  = (r_count != '0) && r_in.ack_intact
                     && (r_in.ack_number >= r_base) && (r_in.ack_number < r_next);

    assign rd_addr = i_cmd.decide ? r_head : r_rd_slot;
    assign rd_inc  = (rd_addr == TOP_SLOT) ? '0 : rd_addr + AW'(1);

    assign o_stat.replay_start = (r_in.action == gbn_pkg::ACT_TIMEOUT) && (r_count != '0);
    assign o_stat.replay_last  = ({1'b0, r_idx} == r_count - 4'd1);

    assign dec_emit = !o_stat.replay_start;
    assign ring_we  = i_cmd.decide && (r_in.action == gbn_pkg::ACT_SEND) && send_ok;

    always_comb begin
        dec_res = '0;
        n_count = r_count;
        case (r_in.action)
            gbn_pkg::ACT_SEND: begin
                if (send_ok) begin
                    n_count             = r_count + 4'd1;
                    dec_res.result_kind = gbn_pkg::KIND_NEW;
                    dec_res.packet_seq  = r_next;
                    dec_res.packet_tag  = r_in.payload_tag;
                    if (r_count == '0) begin
                        dec_res.timer_action = gbn_pkg::TMR_START;
                        dec_res.timer_seq    = r_next;
                    end
                end else begin
                    dec_res.result_kind = gbn_pkg::KIND_REFUSED;
                end
            end
            gbn_pkg::ACT_ACK: begin
                if (ack_ok) begin
                    n_count             = r_count - ack_num;
                    dec_res.result_kind = gbn_pkg::KIND_ACK_OK;
                    if (ack_plus1 == r_next) begin
                        dec_res.timer_action = gbn_pkg::TMR_STOP;
                        dec_res.timer_seq    = r_base;
                    end else begin
                        dec_res.timer_action = gbn_pkg::TMR_RESTART;
                        dec_res.timer_seq    = ack_plus1;
                    end
                end else begin
                    dec_res.result_kind = gbn_pkg::KIND_ACK_IGN;
                end
            end
            gbn_pkg::ACT_TIMEOUT: begin
                dec_res.result_kind = gbn_pkg::KIND_TMO_EMPTY;
            end
            default: begin
                dec_res.result_kind = gbn_pkg::KIND_ACK_IGN;
            end
        endcase
        dec_res.window_full = (n_count >= eff);
        dec_res.in_flight   = n_count;
        dec_res.last        = 1'b1;
    end

    always_comb begin
        rep_res              = '0;
        rep_res.result_kind  = gbn_pkg::KIND_RETX;
        rep_res.packet_seq   = r_base + gbn_pkg::SEQ_W'(r_idx);
        rep_res.packet_tag   = r_rd_tag;
        if (r_idx == '0) begin
            rep_res.timer_action = gbn_pkg::TMR_RESTART;
            rep_res.timer_seq    = r_base;
        end
        rep_res.window_full  = (r_count >= eff);
        rep_res.in_flight    = r_count;
        rep_res.last         = o_stat.replay_last;
    end

    // tag ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring[wr_slot] <= r_in.payload_tag;
        end
        if (i_cmd.decide || i_cmd.replay) begin
            r_rd_tag <= ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in;
        end
        if (i_cmd.decide || i_cmd.replay) begin
            r_rd_slot <= rd_inc;
        end
        if (i_cmd.decide) begin
            r_idx <= '0;
        end else if (i_cmd.replay) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.decide) begin
            r_res <= dec_res;
        end else if (i_cmd.replay) begin
            r_res <= rep_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize  <= gbn_pkg::WSIZE_RESET;
            r_base   <= 32'd1;
            r_next   <= 32'd1;
            r_count  <= '0;
            r_head   <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wsize <= i_cfg_wdata;
            end
            r_strobe <= (i_cmd.decide && dec_emit) || i_cmd.replay;
            if (i_cmd.decide) begin
                r_count <= n_count;
                if (r_in.action == gbn_pkg::ACT_SEND && send_ok) begin
                    r_next <= r_next + 32'd1;
                end
                if (r_in.action == gbn_pkg::ACT_ACK && ack_ok) begin
                    r_base <= ack_plus1;
                    r_head <= ack_head;
                end
            end
        end
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

endmodule

FILE: rtl/core/go_back_n_sender.sv
// Top level of the go-back-n sender window control.
//
// Accepts one event beat (send request, ack or timer expiry) when start is
// high and busy is low. A send, an ack or a timeout on an empty window goes
// through accept, then decide, and yields one result beat in the cycle
// after the decision; busy is already low in that cycle, so the next event can
// be taken while that result is shown. A timeout with N packets in flight
// passes through accept, decide and replay and yields N retransmit beats on
// consecutive cycles, one per cycle, paced by the single read port of the tag
// ring. Results are strobed on o_res_strobe for exactly one cycle each and
// cannot be stalled; the final beat of an event carries last. Write the window
// size only while busy is low and no result beat is pending. The tag ring has
// no reset; only tags of in-flight packets reach a result beat.
module go_back_n_sender #(
    parameter int WINDOW_DEPTH = gbn_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  gbn_pkg::t_gbn_in             i_in,
    input  logic                         i_cfg_we,
    input  logic [gbn_pkg::WSIZE_W-1:0]  i_cfg_wdata,
    output logic                         o_res_strobe,
    output gbn_pkg::t_gbn_out            o_res
);

    gbn_pkg::t_gbn_cmd  cmd;
    gbn_pkg::t_gbn_stat stat;

    // sequence the event: accept, decide, replay the ring on timeout
    gbn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // hold window state, tag ring and the result register
    gbn_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in         (i_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule

FILE: rtl/core/gbn_chk.sv
// Port-level checks for the go-back-n sender, bound to the top level.
module gbn_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input gbn_pkg::t_gbn_out  o_res,
    input logic               o_res_strobe
);

    // an accepted event always occupies the block for its decision cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted event");

    // the final beat of an event is never directly followed by another beat
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.last |=> !o_res_strobe)
        else $error("result beat right after final beat");

    // a retransmit burst runs back to back with consecutive sequence numbers
    a_retx_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && !o_res.last |=> o_res_strobe
            && o_res.result_kind == gbn_pkg::KIND_RETX
            && o_res.packet_seq == $past(o_res.packet_seq) + 32'd1)
        else $error("retransmit burst broken");

    // in-flight count never exceeds the largest window
    a_in_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> o_res.in_flight <= 4'd8)
        else $error("in-flight count out of range");

endmodule

bind go_back_n_sender gbn_chk u_gbn_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res        (o_res),
    .o_res_strobe (o_res_strobe)
);

FILE: dv/tb_go_back_n_sender.sv
// Self-checking testbench for the go-back-n sender window control.
module tb_go_back_n_sender;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD      = 20;
    localparam int unsigned WATCHDOG_CYCLES = 100_000;
    // Action code 3 has no meaning; the block must treat it as an ignored ack.
    localparam logic [1:0]  ACT_SPARE       = 2'd3;

    // Track the sender window the way the block should, and hold the result
    // beats that each accepted event is due to produce, oldest first.
    class gbn_window_tracker;
        logic [gbn_pkg::WSIZE_W-1:0] wsize;
        logic [gbn_pkg::SEQ_W-1:0]   base;
        logic [gbn_pkg::SEQ_W-1:0]   next_seq;
        int unsigned                 outstanding;
        int unsigned                 head;
        logic [gbn_pkg::TAG_W-1:0]   tags [gbn_pkg::WINDOW_DEPTH_DEF];
        gbn_pkg::t_gbn_out           beats_due [$];
        int                          errors;

        function new();
            wsize       = gbn_pkg::WSIZE_RESET;
            base        = 1;
            next_seq    = 1;
            outstanding = 0;
            head        = 0;
            errors      = 0;
            foreach (tags[i]) tags[i] = '0;
        endfunction

        // The window actually in force: never wider than the ring or the burst.
        function int unsigned open_window();
            int unsigned w;
            w = wsize;
            if (w > gbn_pkg::WINDOW_DEPTH_DEF) w = gbn_pkg::WINDOW_DEPTH_DEF;
            if (w > gbn_pkg::MAX_BURST) w = gbn_pkg::MAX_BURST;
            return w;
        endfunction

        // Advance the window by one accepted event and queue its beats.
        function void log_event(gbn_pkg::t_gbn_in ev);
            gbn_pkg::t_gbn_out         r;
            gbn_pkg::t_gbn_out         burst [$];
            logic [gbn_pkg::SEQ_W-1:0] old_base;
            logic [gbn_pkg::SEQ_W-1:0] span;
            int unsigned               win;
            int unsigned               cnt;
            win = open_window();
            r   = '0;
            case (ev.action)
                gbn_pkg::ACT_SEND: begin
                    if (outstanding < win && next_seq != '1) begin
                        tags[(head + outstanding) % gbn_pkg::WINDOW_DEPTH_DEF] = ev.payload_tag;
                        r.result_kind = gbn_pkg::KIND_NEW;
                        r.packet_seq  = next_seq;
                        r.packet_tag  = ev.payload_tag;
                        if (outstanding == 0) begin
                            r.timer_action = gbn_pkg::TMR_START;
                            r.timer_seq    = next_seq;
                        end
                        outstanding++;
                        next_seq++;
                    end else begin
                        r.result_kind = gbn_pkg::KIND_REFUSED;
                    end
                    burst.push_back(r);
                end
                gbn_pkg::ACT_ACK: begin
                    if (outstanding > 0 && ev.ack_intact && ev.ack_number >= base &&
                        ev.ack_number < next_seq) begin
                        old_base = base;
                        span     = ev.ack_number - base + 1;
                        if (span > outstanding) span = outstanding;
                        base        = ev.ack_number + 1;
                        outstanding = outstanding - span;
                        head        = (head + span) % gbn_pkg::WINDOW_DEPTH_DEF;
                        r.result_kind = gbn_pkg::KIND_ACK_OK;
                        if (base == next_seq) begin
                            r.timer_action = gbn_pkg::TMR_STOP;
                            r.timer_seq    = old_base;
                        end else begin
                            r.timer_action = gbn_pkg::TMR_RESTART;
                            r.timer_seq    = base;
                        end
                    end else begin
                        r.result_kind = gbn_pkg::KIND_ACK_IGN;
                    end
                    burst.push_back(r);
                end
                gbn_pkg::ACT_TIMEOUT: begin
                    if (outstanding == 0) begin
                        r.result_kind = gbn_pkg::KIND_TMO_EMPTY;
                        burst.push_back(r);
                    end else begin
                        cnt = (outstanding > gbn_pkg::MAX_BURST) ? gbn_pkg::MAX_BURST
                                                                 : outstanding;
                        for (int i = 0; i < cnt; i++) begin
                            r = '0;
                            r.result_kind = gbn_pkg::KIND_RETX;
                            r.packet_seq  = base + i;
                            r.packet_tag  = tags[(head + i) % gbn_pkg::WINDOW_DEPTH_DEF];
                            if (i == 0) begin
                                r.timer_action = gbn_pkg::TMR_RESTART;
                                r.timer_seq    = base;
                            end
                            burst.push_back(r);
                        end
                    end
                end
                default: begin
                    r.result_kind = gbn_pkg::KIND_ACK_IGN;
                    burst.push_back(r);
                end
            endcase
            foreach (burst[k]) begin
                burst[k].window_full = (outstanding >= win);
                burst[k].in_flight   = gbn_pkg::CNT_W'(outstanding);
                burst[k].last        = (k == burst.size() - 1);
                beats_due.push_back(burst[k]);
            end
        endfunction

        function void compare_field(string field, logic [gbn_pkg::SEQ_W-1:0] want,
                                    logic [gbn_pkg::SEQ_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        // Match one result beat against the oldest beat still due.
        function void check_beat(gbn_pkg::t_gbn_out got);
            gbn_pkg::t_gbn_out want;
            if (beats_due.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
                errors++;
                return;
            end
            want = beats_due.pop_front();
            compare_field("result_kind",  want.result_kind,  got.result_kind);
            compare_field("packet_seq",   want.packet_seq,   got.packet_seq);
            compare_field("packet_tag",   want.packet_tag,   got.packet_tag);
            compare_field("timer_action", want.timer_action, got.timer_action);
            compare_field("timer_seq",    want.timer_seq,    got.timer_seq);
            compare_field("window_full",  want.window_full,  got.window_full);
            compare_field("in_flight",    want.in_flight,    got.in_flight);
            compare_field("last",         want.last,         got.last);
        endfunction
    endclass

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        start       = 1'b0;
    logic                        busy;
    gbn_pkg::t_gbn_in            i_in        = '0;
    logic                        i_cfg_we    = 1'b0;
    logic [gbn_pkg::WSIZE_W-1:0] i_cfg_wdata = '0;
    logic                        o_res_strobe;
    gbn_pkg::t_gbn_out           o_res;

    gbn_window_tracker tracker = new();

    go_back_n_sender uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_in         (i_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Results cannot be held off: check every strobed beat at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_res_strobe === 1'b1) begin
            tracker.check_beat(o_res);
        end
    end

    function automatic gbn_pkg::t_gbn_in make_event(logic [1:0] act,
                                                    logic [gbn_pkg::TAG_W-1:0] tag,
                                                    logic [gbn_pkg::SEQ_W-1:0] ackn,
                                                    logic intact);
        gbn_pkg::t_gbn_in ev;
        ev.action      = act;
        ev.payload_tag = tag;
        ev.ack_number  = ackn;
        ev.ack_intact  = intact;
        return ev;
    endfunction

    // Pick the next random event from the current window, so that most acks
    // land inside it; the rest is noise that the block has to ignore.
    function automatic gbn_pkg::t_gbn_in next_event();
        gbn_pkg::t_gbn_in ev;
        int unsigned      pick;
        ev   = make_event(gbn_pkg::ACT_SEND, gbn_pkg::TAG_W'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            ev.action = gbn_pkg::ACT_SEND;
        end else if (pick < 65) begin
            ev.action = gbn_pkg::ACT_ACK;
            if (tracker.outstanding > 0) begin
                ev.ack_intact = 1'b1;
                // Lean toward full retirement now and then to exercise the stop.
                if ($urandom_range(0, 3) == 0)
                    ev.ack_number = tracker.next_seq - 1;
                else
                    ev.ack_number = tracker.base + $urandom_range(0, tracker.outstanding - 1);
            end
        end else if (pick < 80) begin
            ev.action = gbn_pkg::ACT_TIMEOUT;
        end else begin
            ev.action = gbn_pkg::ACT_ACK;
            case ($urandom_range(0, 4))
                0: ;  // fully random number and check flag
                1: begin
                    ev.ack_intact = 1'b0;
                    ev.ack_number = tracker.base;
                end
                2: ev.ack_number = tracker.next_seq;
                3: ev.ack_number = tracker.base - 1;
                default: ev.action = ACT_SPARE;
            endcase
        end
        return ev;
    endfunction

    // Present one event beat and hold it until the block takes it. An idle
    // stretch, when drawn, drops start first and raises it again after a random gap.
    task automatic drive_event(input gbn_pkg::t_gbn_in ev, input int idle_pct);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_in  <= ev;
        do @(posedge i_clk); while (busy);
        tracker.log_event(ev);
    endtask

    // Drop start and wait until every due beat has come and the block is idle.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.beats_due.size() != 0 || busy !== 1'b0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write the window size only once the block has gone quiet.
    task automatic write_window(input logic [gbn_pkg::WSIZE_W-1:0] wsz);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wsz;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.wsize = wsz;
    endtask

    task automatic run_events(ref gbn_pkg::t_gbn_in list [$]);
        foreach (list[i]) drive_event(list[i], 0);
        list.delete();
    endtask

    // Random phases: window size, percent of sender idling, events per phase.
    int ph_wsize [6] = '{8, 3, 1, 15, 0, 5};
    int ph_idle  [6] = '{0, 52, 11, 52, 0, 11};
    int ph_count [6] = '{45, 35, 25, 35, 8, 35};

    initial begin
        gbn_pkg::t_gbn_in directed [$];

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty window: timeout with nothing in flight, ack with nothing to retire.
        directed.push_back(make_event(gbn_pkg::ACT_TIMEOUT, '0, '0, 1'b0));
        directed.push_back(make_event(gbn_pkg::ACT_ACK, '0, 32'd1, 1'b1));
        // Fill the default window, tags at both extremes, then overrun it.
        directed.push_back(make_event(gbn_pkg::ACT_SEND, '0, '1, 1'b1));
        directed.push_back(make_event(gbn_pkg::ACT_SEND, '1, '0, 1'b0));
        for (int i = 0; i < 6; i++)
            directed.push_back(make_event(gbn_pkg::ACT_SEND, gbn_pkg::TAG_W'($urandom),
                                          $urandom, 1'b0));
        directed.push_back(make_event(gbn_pkg::ACT_SEND, gbn_pkg::TAG_W'($urandom), '0, 1'b0));
        // Replay the full window, then every reason to ignore an ack.
        directed.push_back(make_event(gbn_pkg::ACT_TIMEOUT, '0, '0, 1'b0));
        directed.push_back(make_event(gbn_pkg::ACT_ACK, '0, 32'd5, 1'b0));
        directed.push_back(make_event(gbn_pkg::ACT_ACK, '0, 32'd0, 1'b1));
        directed.push_back(make_event(gbn_pkg::ACT_ACK, '1, '1, 1'b1));
        directed.push_back(make_event(gbn_pkg::ACT_ACK, '0, 32'd9, 1'b1));
        // Partial retirement restarts the timer, the spare code is ignored,
        // and retiring the rest stops the timer on the old base.
        directed.push_back(make_event(gbn_pkg::ACT_ACK, '0, 32'd3, 1'b1));
        directed.push_back(make_event(ACT_SPARE, '1, '1, 1'b1));
        directed.push_back(make_event(gbn_pkg::ACT_ACK, '0, 32'd8, 1'b1));
        for (int i = 0; i < 3; i++)
            directed.push_back(make_event(gbn_pkg::ACT_SEND, gbn_pkg::TAG_W'($urandom),
                                          '0, 1'b0));
        run_events(directed);

        // Shrink the window below what is in flight: nothing may be dropped.
        write_window(4'd2);
        directed.push_back(make_event(gbn_pkg::ACT_SEND, gbn_pkg::TAG_W'($urandom), '0, 1'b0));
        directed.push_back(make_event(gbn_pkg::ACT_TIMEOUT, '0, '0, 1'b0));
        directed.push_back(make_event(gbn_pkg::ACT_ACK, '0, 32'd9, 1'b1));
        directed.push_back(make_event(gbn_pkg::ACT_ACK, '0, 32'd11, 1'b1));
        run_events(directed);

        // A zero window refuses every send.
        write_window(4'd0);
        directed.push_back(make_event(gbn_pkg::ACT_SEND, gbn_pkg::TAG_W'($urandom), '0, 1'b0));
        run_events(directed);

        for (int p = 0; p < 6; p++) begin
            write_window(gbn_pkg::WSIZE_W'(ph_wsize[p]));
            for (int n = 0; n < ph_count[p]; n++) begin
                drive_event(next_event(), ph_idle[p]);
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.beats_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Bound the run far above the slowest correct one.
    initial begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("%0t: timeout with %0d beats still due", $time, tracker.beats_due.size());
        $display("tb: failure");
        $finish;
    end

endmodule
